FILE: rtl/core/wmor_pkg.sv
// Shared types, defaults and codes for the windowed mean outlier rejector.
`timescale 1ns / 1ps

package wmor_pkg;

    // Fixed field widths.
    localparam int DATA_W    = 16;
    localparam int CH_IN_W   = 3;
    localparam int CFG_IDX_W = 1;

    // Parameter defaults.
    localparam int WINDOW_LENGTH_DEF = 8;
    localparam int CHANNEL_COUNT_DEF = 8;

    // Configuration register reset values.
    localparam logic [DATA_W-1:0] DEV_LIMIT_RST   = 16'd100;
    localparam logic [DATA_W-1:0] MAX_READING_RST = 16'd4000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_READING = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_HI_ADD,
        ST_HI_CMP,
        ST_LO_SUB,
        ST_LO_CMP,
        ST_MAX_CMP,
        ST_FINISH
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_hist_ctl;

endpackage

FILE: rtl/core/wmor_if.sv
// Valid/ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps

interface wmor_in_if;
    logic                           valid;
    logic                           ready;
    logic [wmor_pkg::CH_IN_W-1:0]   channel;
    logic [wmor_pkg::DATA_W-1:0]    reading;

    modport source (output valid, output channel, output reading, input ready);
    modport sink   (input valid, input channel, input reading, output ready);
endinterface

interface wmor_out_if;
    logic                           valid;
    logic                           ready;
    logic [wmor_pkg::CH_IN_W-1:0]   out_channel;
    logic [wmor_pkg::DATA_W-1:0]    filtered_reading;
    logic                           was_replaced;

    modport source (output valid, output out_channel, output filtered_reading,
                    output was_replaced, input ready);
    modport sink   (input valid, input out_channel, input filtered_reading,
                    input was_replaced, output ready);
endinterface

FILE: rtl/core/wmor_alu.sv
// Shared add/subtract unit with borrow flag used for sums and compares.
`timescale 1ns / 1ps

module wmor_alu #(
    parameter int ALU_W = 19
) (
    input  wmor_pkg::t_alu_op i_op,
    input  logic [ALU_W-1:0]  i_a,
    input  logic [ALU_W-1:0]  i_b,
    output logic [ALU_W-1:0]  o_res,
    output logic              o_borrow
);

    logic [ALU_W:0] wide;

    always_comb begin
        case (i_op)
            wmor_pkg::ALU_SUB: wide = {1'b0, i_a} - {1'b0, i_b};
            default:           wide = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end

    // For a subtraction the top bit is set exactly when b exceeds a.
    assign o_res    = wide[ALU_W-1:0];
    assign o_borrow = wide[ALU_W];

endmodule

FILE: rtl/core/wmor_hist.sv
// Per-channel history memory with circular write pointers and fill counts.
`timescale 1ns / 1ps

module wmor_hist #(
    parameter int WINDOW_LENGTH = wmor_pkg::WINDOW_LENGTH_DEF,
    parameter int CHANNEL_COUNT = wmor_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wmor_pkg::t_hist_ctl                 i_ctl,
    input  logic [((CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1)-1:0] i_ch,
    input  logic [$clog2(WINDOW_LENGTH)-1:0]    i_slot,
    input  logic [wmor_pkg::DATA_W-1:0]         i_wdata,
    output logic [wmor_pkg::DATA_W-1:0]         o_rdata
);

    localparam int LOG_W = $clog2(WINDOW_LENGTH);
    localparam int CNT_W = LOG_W + 1;
    localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int ADR_W = CH_W + LOG_W;
    localparam int DEPTH = 1 << ADR_W;

    logic [wmor_pkg::DATA_W-1:0] mem [DEPTH];
    logic [LOG_W-1:0]            r_ptr  [CHANNEL_COUNT];
    logic [CNT_W-1:0]            r_fill [CHANNEL_COUNT];
    logic [wmor_pkg::DATA_W-1:0] r_raw;
    logic                        r_hit;
    logic [LOG_W-1:0]            cur_ptr;
    logic [CNT_W-1:0]            cur_fill;

    assign cur_ptr  = r_ptr[i_ch];
    assign cur_fill = r_fill[i_ch];

    // A slot that has never been written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[{i_ch, cur_ptr}] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_raw <= mem[{i_ch, i_slot}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_ptr[c]  <= '0;
                r_fill[c] <= '0;
            end
            r_hit <= 1'b0;
        end else begin
            if (i_ctl.rd_en) begin
                r_hit <= ({1'b0, i_slot} < cur_fill);
            end
            if (i_ctl.wr_en) begin
                r_ptr[i_ch] <= (cur_ptr == LOG_W'(WINDOW_LENGTH - 1)) ?
                               '0 : cur_ptr + 1'b1;
                if (cur_fill != CNT_W'(WINDOW_LENGTH)) begin
                    r_fill[i_ch] <= cur_fill + 1'b1;
                end
            end
        end
    end

    assign o_rdata = r_hit ? r_raw : '0;

endmodule

FILE: rtl/core/windowed_mean_outlier_rejector_unit.sv
// Top level of the windowed mean outlier rejector: sequencer and datapath.
`timescale 1ns / 1ps

// Each input transaction carries a channel number and a distance reading in
// millimetres. For a present channel the block sums the channel's last
// WINDOW_LENGTH stored values one memory read per cycle, turns the sum into a
// truncated mean with a single multiply by a reciprocal constant, and then runs
// five add or compare steps through one shared adder to decide whether the
// reading is an outlier (more than deviation_limit above or below the mean, or
// above max_valid_reading). An outlier is replaced by the mean. The chosen value
// is written into the channel's window and returned with a replaced flag. A
// channel number at or above CHANNEL_COUNT passes the reading through untouched.
// A transaction's run from acceptance to the result register is set by the
// serial window read through the single memory read port; the input is not
// ready during that time, and a new transaction can be accepted only once the
// block is back in idle after its final step. A channel that is not present
// skips the window work and goes from idle straight to the final step, which
// loads the result register. The result register frees the input side: the
// next transaction can be accepted while the previous result still waits, and
// the block only holds in its final step when the result register is still
// occupied. Windows read as zero after reset through per-channel fill counts,
// so no clearing pass is needed and the block is ready as soon as reset is
// released. Configuration registers are to be written through the plain write
// port only while the block is idle; the block itself does not enforce this.
module windowed_mean_outlier_rejector_unit #(
    parameter int WINDOW_LENGTH = wmor_pkg::WINDOW_LENGTH_DEF,
    parameter int CHANNEL_COUNT = wmor_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    wmor_in_if.sink                             i_in,
    wmor_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [wmor_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wmor_pkg::DATA_W-1:0]         i_cfg_data
);

    localparam int DATA_W  = wmor_pkg::DATA_W;
    localparam int LOG_W   = $clog2(WINDOW_LENGTH);
    localparam int CNT_W   = LOG_W + 1;
    localparam int ALU_W   = DATA_W + LOG_W;
    localparam int SHIFT   = ALU_W + LOG_W;
    localparam int PROD_W  = 2 * ALU_W + 1;
    localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int CMP_W   = wmor_pkg::CH_IN_W + 2;
    // Rounded-up reciprocal: (sum * MAGIC) >> SHIFT is the exact floor of
    // sum / WINDOW_LENGTH for every sum that fits in ALU_W bits.
    localparam int unsigned MAGIC_I =
        ((32'd1 << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam logic [ALU_W:0] MAGIC_V = (ALU_W + 1)'(MAGIC_I);

    wmor_pkg::t_state             r_state;
    wmor_pkg::t_state             n_state;

    logic [wmor_pkg::CH_IN_W-1:0] r_ch;
    logic [DATA_W-1:0]            r_rd;
    logic [ALU_W-1:0]             r_acc;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_pend;
    logic [PROD_W-1:0]            r_prod;
    logic [ALU_W-1:0]             r_t;
    logic                         r_lo_ok;
    logic                         r_outlier;
    logic [DATA_W-1:0]            r_dev;
    logic [DATA_W-1:0]            r_max;

    logic                         r_ov;
    logic [wmor_pkg::CH_IN_W-1:0] r_oc;
    logic [DATA_W-1:0]            r_of;
    logic                         r_orep;

    // Sequencer outputs.
    logic                         in_ready;
    wmor_pkg::t_alu_op            alu_op;
    logic [ALU_W-1:0]             alu_a;
    logic [ALU_W-1:0]             alu_b;
    logic                         load_out;
    wmor_pkg::t_hist_ctl          hist_ctl;

    logic [ALU_W-1:0]             alu_res;
    logic                         alu_borrow;
    logic [DATA_W-1:0]            hist_rdata;
    logic [DATA_W-1:0]            mean;
    logic [DATA_W-1:0]            chosen;
    logic                         in_ch_ok;
    logic                         ch_ok;
    logic                         in_take;

    assign mean     = r_prod[SHIFT +: DATA_W];
    assign chosen   = r_outlier ? mean : r_rd;
    assign in_ch_ok = ({2'b00, i_in.channel} < CMP_W'(CHANNEL_COUNT));
    assign ch_ok    = ({2'b00, r_ch} < CMP_W'(CHANNEL_COUNT));
    assign in_take  = i_in.valid && in_ready;

    wmor_alu #(
        .ALU_W(ALU_W)
    ) u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    wmor_hist #(
        .WINDOW_LENGTH(WINDOW_LENGTH),
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hist_ctl),
        .i_ch    (CH_W'(r_ch)),
        .i_slot  (r_idx[LOG_W-1:0]),
        .i_wdata (chosen),
        .o_rdata (hist_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            wmor_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = in_ch_ok ? wmor_pkg::ST_SUM : wmor_pkg::ST_FINISH;
                end
            end
            wmor_pkg::ST_SUM: begin
                if (r_idx == CNT_W'(WINDOW_LENGTH)) begin
                    n_state = wmor_pkg::ST_MUL;
                end
            end
            wmor_pkg::ST_MUL:     n_state = wmor_pkg::ST_HI_ADD;
            wmor_pkg::ST_HI_ADD:  n_state = wmor_pkg::ST_HI_CMP;
            wmor_pkg::ST_HI_CMP:  n_state = wmor_pkg::ST_LO_SUB;
            wmor_pkg::ST_LO_SUB:  n_state = wmor_pkg::ST_LO_CMP;
            wmor_pkg::ST_LO_CMP:  n_state = wmor_pkg::ST_MAX_CMP;
            wmor_pkg::ST_MAX_CMP: n_state = wmor_pkg::ST_FINISH;
            wmor_pkg::ST_FINISH: begin
                if (!r_ov || o_out.ready) begin
                    n_state = wmor_pkg::ST_IDLE;
                end
            end
            default: n_state = wmor_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: operand selection for the shared adder and memory
    // control. Every compare is a subtraction whose borrow answers it.
    always_comb begin
        in_ready       = 1'b0;
        alu_op         = wmor_pkg::ALU_ADD;
        alu_a          = r_acc;
        alu_b          = ALU_W'(hist_rdata);
        load_out       = 1'b0;
        hist_ctl.rd_en = 1'b0;
        hist_ctl.wr_en = 1'b0;
        case (r_state)
            wmor_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            wmor_pkg::ST_SUM: begin
                hist_ctl.rd_en = (r_idx < CNT_W'(WINDOW_LENGTH));
            end
            wmor_pkg::ST_HI_ADD: begin
                alu_a = ALU_W'(mean);
                alu_b = ALU_W'(r_dev);
            end
            wmor_pkg::ST_HI_CMP: begin
                alu_op = wmor_pkg::ALU_SUB;
                alu_a  = r_t;
                alu_b  = ALU_W'(r_rd);
            end
            wmor_pkg::ST_LO_SUB: begin
                alu_op = wmor_pkg::ALU_SUB;
                alu_a  = ALU_W'(mean);
                alu_b  = ALU_W'(r_dev);
            end
            wmor_pkg::ST_LO_CMP: begin
                alu_op = wmor_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_rd);
                alu_b  = r_t;
            end
            wmor_pkg::ST_MAX_CMP: begin
                alu_op = wmor_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_max);
                alu_b  = ALU_W'(r_rd);
            end
            wmor_pkg::ST_FINISH: begin
                load_out       = !r_ov || o_out.ready;
                hist_ctl.wr_en = load_out && ch_ok;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmor_pkg::ST_IDLE;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
            r_dev   <= wmor_pkg::DEV_LIMIT_RST;
            r_max   <= wmor_pkg::MAX_READING_RST;
        end else begin
            r_state <= n_state;
            r_pend  <= hist_ctl.rd_en;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wmor_pkg::CFG_DEV_LIMIT:   r_dev <= i_cfg_data;
                    wmor_pkg::CFG_MAX_READING: r_max <= i_cfg_data;
                    default:                   r_dev <= r_dev;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch      <= i_in.channel;
            r_rd      <= i_in.reading;
            r_acc     <= '0;
            r_idx     <= '0;
            r_outlier <= 1'b0;
        end
        case (r_state)
            wmor_pkg::ST_SUM: begin
                if (hist_ctl.rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_pend) begin
                    r_acc <= alu_res;
                end
            end
            wmor_pkg::ST_MUL: begin
                r_prod <= PROD_W'(r_acc) * PROD_W'(MAGIC_V);
            end
            wmor_pkg::ST_HI_ADD: begin
                r_t <= alu_res;
            end
            wmor_pkg::ST_HI_CMP: begin
                r_outlier <= alu_borrow;
            end
            wmor_pkg::ST_LO_SUB: begin
                r_t     <= alu_res;
                r_lo_ok <= !alu_borrow;
            end
            wmor_pkg::ST_LO_CMP: begin
                if (alu_borrow && r_lo_ok) begin
                    r_outlier <= 1'b1;
                end
            end
            wmor_pkg::ST_MAX_CMP: begin
                if (alu_borrow) begin
                    r_outlier <= 1'b1;
                end
            end
            default: begin
                r_t <= r_t;
            end
        endcase
        if (load_out) begin
            r_oc   <= r_ch;
            r_of   <= chosen;
            r_orep <= r_outlier;
        end
    end

    assign i_in.ready             = in_ready;
    assign o_out.valid            = r_ov;
    assign o_out.out_channel      = r_oc;
    assign o_out.filtered_reading = r_of;
    assign o_out.was_replaced     = r_orep;

endmodule

FILE: rtl/core/wmor_chk.sv
// Port-level checker for the outlier rejector, bound to the top level.
`timescale 1ns / 1ps

module wmor_chk #(
    parameter int CHANNEL_COUNT = wmor_pkg::CHANNEL_COUNT_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [wmor_pkg::CH_IN_W-1:0]     i_out_channel,
    input logic [wmor_pkg::DATA_W-1:0]      i_out_reading,
    input logic                             i_out_replaced
);

    localparam int CMP_W = wmor_pkg::CH_IN_W + 2;

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted transaction");

    // A new result is only produced while the input side is busy.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without work in progress");

    // Channels that are not present are never filtered.
    a_absent_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && ({2'b00, i_out_channel} >= CMP_W'(CHANNEL_COUNT)))
        |-> !i_out_replaced)
        else $error("replacement on a channel that is not present");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_channel) && $stable(i_out_reading)
         && $stable(i_out_replaced)))
        else $error("stalled result transaction changed");

endmodule

bind windowed_mean_outlier_rejector_unit wmor_chk #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
) u_wmor_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_channel  (o_out.out_channel),
    .i_out_reading  (o_out.filtered_reading),
    .i_out_replaced (o_out.was_replaced)
);

FILE: test/tb_windowed_mean_outlier_rejector_unit.sv
// Self-checking testbench for the windowed mean outlier rejector unit.
`timescale 1ns / 1ps

// The bench drives reading transactions into the block through a driver that
// is fed from a queue, predicts each filtered result at the moment the input
// transaction is accepted, and compares every result transaction field by
// field against the oldest prediction. The predictor keeps its own copy of
// the per-channel history windows and of the two limit registers.
//
// The run starts with a short directed part that hits the reading extremes,
// the maximum-reading boundary, a window filled to a known mean, readings
// just inside and outside the deviation band, and the case where the mean is
// below the deviation limit so the low-side test must be skipped. After that
// come six random phases, each with its own register setting and its own
// idling pattern on both handshakes. Between phases the sender pauses until
// every predicted result has come back, and only then are registers written.
module tb_windowed_mean_outlier_rejector_unit;

    import wmor_pkg::*;

    localparam int WIN_LEN        = WINDOW_LENGTH_DEF;
    localparam int CH_CNT         = CHANNEL_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_PRINTS     = 100;

    typedef struct packed {
        logic [CH_IN_W-1:0] channel;
        logic [DATA_W-1:0]  reading;
    } reading_t;

    typedef struct packed {
        logic [CH_IN_W-1:0] channel;
        logic [DATA_W-1:0]  value;
        logic               replaced;
    } filtered_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_data;

    wmor_in_if  in_bus ();
    wmor_out_if out_bus ();

    windowed_mean_outlier_rejector_unit #(
        .WINDOW_LENGTH (WIN_LEN),
        .CHANNEL_COUNT (CH_CNT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state: the history windows and the shadow register values.
    logic [DATA_W-1:0] win_mem [CH_CNT][WIN_LEN];
    logic [DATA_W-1:0] dev_limit;
    logic [DATA_W-1:0] max_reading;

    reading_t  readings_q[$];
    filtered_t filtered_q[$];

    // Per-channel level that random readings cluster around in a phase.
    logic [DATA_W-1:0] chan_level [CH_CNT];

    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_arm;
    int          hold_left;
    int          stall_cycles;
    int          mismatches;
    logic [15:0] rnd_dev;
    logic [15:0] rnd_max;

    // Computes the filtered result for one reading and shifts the chosen value
    // into the channel's window, newest first.
    function automatic filtered_t filter_reading(logic [CH_IN_W-1:0] ch,
                                                 logic [DATA_W-1:0] rd);
        logic [31:0] sum;
        logic [31:0] mean;
        logic [31:0] lim;
        logic        outlier;
        filtered_t   res;
        res.channel  = ch;
        res.value    = rd;
        res.replaced = 1'b0;
        if (ch < CH_CNT) begin
            sum = 32'd0;
            for (int k = 0; k < WIN_LEN; k++) begin
                sum += 32'(win_mem[ch][k]);
            end
            mean = sum / WIN_LEN;
            lim  = 32'(dev_limit);
            // The low-side bound only exists when the mean is at least the limit.
            outlier = (32'(rd) > mean + lim)
                   || (mean >= lim && 32'(rd) < mean - lim)
                   || (rd > max_reading);
            if (outlier) begin
                res.value    = mean[DATA_W-1:0];
                res.replaced = 1'b1;
            end
            for (int k = WIN_LEN - 1; k > 0; k--) begin
                win_mem[ch][k] = win_mem[ch][k-1];
            end
            win_mem[ch][0] = res.value;
        end
        return res;
    endfunction

    // Random reading: mostly near the channel's level, some around the
    // maximum-reading boundary, and the rest anywhere in the full range.
    function automatic reading_t make_reading();
        reading_t it;
        int       pick;
        int       lvl;
        int       spread;
        it.channel = CH_IN_W'($urandom_range(0, (1 << CH_IN_W) - 1));
        pick       = $urandom_range(0, 99);
        spread     = ((dev_limit > 16'd2000) ? 2000 : int'(dev_limit)) * 2 + 4;
        if (pick < 70) begin
            lvl = int'(chan_level[it.channel]) + $urandom_range(0, spread) - spread / 2;
        end else if (pick < 85) begin
            lvl = int'(max_reading) + $urandom_range(0, 4) - 2;
        end else begin
            lvl = $urandom_range(0, 65535);
        end
        if (lvl < 0) begin
            lvl = 0;
        end else if (lvl > 65535) begin
            lvl = 65535;
        end
        it.reading = lvl[DATA_W-1:0];
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    task automatic push_item(int ch, int rd);
        reading_t it;
        it.channel = CH_IN_W'(ch);
        it.reading = DATA_W'(rd);
        readings_q.push_back(it);
    endtask

    // Register writes happen only while the block is idle, so the shadow copy
    // can be updated right away.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_DEV_LIMIT) begin
            dev_limit = data;
        end else if (idx == CFG_MAX_READING) begin
            max_reading = data;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Returns at a falling edge once nothing is queued, offered or outstanding.
    task automatic wait_for_idle();
        do begin
            @(negedge clk);
        end while (readings_q.size() != 0 || in_bus.valid || filtered_q.size() != 0);
    endtask

    task automatic run_phase(int n, int send_pct, int recv_pct,
                             logic [DATA_W-1:0] dev, logic [DATA_W-1:0] mx,
                             bit long_hold);
        write_reg(CFG_DEV_LIMIT, dev);
        write_reg(CFG_MAX_READING, mx);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        foreach (chan_level[c]) begin
            chan_level[c] = DATA_W'($urandom_range(0, int'(mx)));
        end
        repeat (n) readings_q.push_back(make_reading());
        // The receiver holds off for a long stretch while the sender keeps
        // offering, so the result register fills and the input stalls.
        if (long_hold) begin
            @(posedge clk);
            hold_arm <= 1'b1;
            @(posedge clk);
            hold_arm <= 1'b0;
        end
        // The sender then pauses until every predicted result has arrived.
        wait_for_idle();
    endtask

    // Input driver: predicts on acceptance, then offers the next reading
    // whenever the slot is free and the idle draw allows it. The valid line is
    // assigned once per edge, so a held valid is never dropped and re-raised.
    always @(posedge clk) begin : reading_driver
        reading_t it;
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                filtered_q.push_back(filter_reading(in_bus.channel, in_bus.reading));
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (readings_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    it = readings_q.pop_front();
                    in_bus.valid   <= 1'b1;
                    in_bus.channel <= it.channel;
                    in_bus.reading <= it.reading;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Counts down the long receiver hold-off once armed.
    always @(posedge clk) begin : hold_counter
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_arm) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: checks every accepted result against the oldest
    // prediction and draws the next ready value.
    always @(posedge clk) begin : result_monitor
        filtered_t want;
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: ch=%0d value=%0d",
                                              out_bus.out_channel, out_bus.filtered_reading));
                end else begin
                    want = filtered_q.pop_front();
                    if (out_bus.out_channel !== want.channel) begin
                        report_mismatch($sformatf("out_channel %0d, predicted %0d",
                                                  out_bus.out_channel, want.channel));
                    end
                    if (out_bus.filtered_reading !== want.value) begin
                        report_mismatch($sformatf("ch %0d filtered_reading %0d, predicted %0d",
                                                  want.channel, out_bus.filtered_reading,
                                                  want.value));
                    end
                    if (out_bus.was_replaced !== want.replaced) begin
                        report_mismatch($sformatf("ch %0d was_replaced %0b, predicted %0b",
                                                  want.channel, out_bus.was_replaced,
                                                  want.replaced));
                    end
                end
            end
            out_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: only cycles with work outstanding and no transaction count.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (readings_q.size() == 0 && !in_bus.valid && filtered_q.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_windowed_mean_outlier_rejector_unit NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_DEV_LIMIT;
        cfg_data       = '0;
        in_bus.valid   = 1'b0;
        in_bus.channel = '0;
        in_bus.reading = '0;
        out_bus.ready  = 1'b0;
        hold_arm       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        dev_limit      = DEV_LIMIT_RST;
        max_reading    = MAX_READING_RST;
        foreach (win_mem[c, k]) begin
            win_mem[c][k] = '0;
        end
        foreach (chan_level[c]) begin
            chan_level[c] = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limits on empty windows: zero, full scale, and the readings at
        // and just above the maximum valid reading.
        push_item(0, 0);
        push_item(0, 65535);
        push_item(7, 4000);
        push_item(7, 4001);
        wait_for_idle();

        // Widest limits let any reading in, which fills one window to a mean
        // of 2000 and leaves another with a mean of 50.
        write_reg(CFG_DEV_LIMIT, 16'hFFFF);
        write_reg(CFG_MAX_READING, 16'hFFFF);
        @(negedge clk);
        repeat (8) push_item(3, 2000);
        push_item(6, 400);
        wait_for_idle();

        // Back to the reset limits: the low band edge passes, a reading far
        // below and one just above the band are replaced, a low reading on a
        // channel whose mean is below the limit passes, and full scale is
        // replaced by the maximum test.
        write_reg(CFG_DEV_LIMIT, DEV_LIMIT_RST);
        write_reg(CFG_MAX_READING, MAX_READING_RST);
        @(negedge clk);
        push_item(3, 1900);
        push_item(3, 1000);
        push_item(3, 2101);
        push_item(6, 0);
        push_item(0, 65535);
        wait_for_idle();

        // Random phases with their own limits and idling patterns.
        run_phase(240, 0, 0, 16'd200, 16'd4000, 1'b0);
        run_phase(240, 78, 0, 16'd0, 16'hFFFF, 1'b0);
        run_phase(240, 0, 78, 16'hFFFF, 16'd0, 1'b0);
        rnd_dev = 16'($urandom_range(1, 3000));
        rnd_max = 16'($urandom_range(1000, 65535));
        run_phase(240, 18, 18, rnd_dev, rnd_max, 1'b0);
        run_phase(250, 0, 0, 16'd500, 16'd3000, 1'b1);
        rnd_dev = 16'($urandom_range(0, 65535));
        rnd_max = 16'($urandom_range(0, 65535));
        run_phase(240, 18, 18, rnd_dev, rnd_max, 1'b0);

        // Let any stray result show up before the verdict.
        repeat (40) @(posedge clk);
        if (filtered_q.size() != 0) begin
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      filtered_q.size()));
        end
        if (mismatches == 0) begin
            $display("tb_windowed_mean_outlier_rejector_unit OK");
        end else begin
            $display("tb_windowed_mean_outlier_rejector_unit NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/wmor_pkg.sv
rtl/core/wmor_if.sv
rtl/core/wmor_alu.sv
rtl/core/wmor_hist.sv
rtl/core/windowed_mean_outlier_rejector_unit.sv
rtl/core/wmor_chk.sv
test/tb_windowed_mean_outlier_rejector_unit.sv
